// ===== design/spcf_pkg.sv =====
// Shared constants, types and command/status structs for the peak centroid finder.
package spcf_pkg;
    localparam int MAG_BINS_DEF = 512;
    localparam int MAG_W = 32;
    localparam int POS_W = 17;
    localparam int LEVEL_W = 34;
    localparam int PART_W = 32;

    typedef struct packed {
        logic clr_step;    // write zero at clear address, advance
        logic sq_start;    // latch operands, begin root
        logic sq_step;     // one squaring or root iteration
        logic sq_write;    // write root into memory
        logic scan_start;  // reset scan best and address
        logic scan_step;   // issue read, compare previous data
        logic nb_start;    // begin reading the three neighbors
        logic nb_step;     // capture one neighbor, issue next read
        logic mul_step;    // one weighted product accumulate
        logic div_start;   // latch dividend, clear remainder and quotient
        logic div_step;    // one quotient bit
        logic zap_step;    // clear one neighbor bin
        logic emit_hit;    // present found result
        logic emit_miss;   // present empty result
    } spcf_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic sq_done;
        logic scan_done;
        logic nb_done;
        logic mul_done;
        logic div_done;
        logic zap_done;
        logic best_zero;
    } spcf_stat_t;
endpackage

// ===== design/spcf_ctrl.sv =====
// Controller state machine sequencing clear, load, scan, centroid and emit.
module spcf_ctrl
    import spcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       mode,
    input  spcf_stat_t stat,
    output spcf_cmd_t  cmd,
    output logic       busy
);
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SQ   = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_NB   = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_ZAP  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;
    localparam logic [3:0] S_WR   = 4'd9;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        busy = (state_reg != S_IDLE);
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (mode)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        cmd.sq_start = 1'b1;
                        state_next = S_SQ;
                    end
                end
            end
            S_SQ:
            begin
                cmd.sq_step = 1'b1;
                if (stat.sq_done) state_next = S_WR;
            end
            S_WR:
            begin
                cmd.sq_write = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    if (stat.best_zero)
                        state_next = S_EMIT;
                    else
                    begin
                        cmd.nb_start = 1'b1;
                        state_next = S_NB;
                    end
                end
            end
            S_NB:
            begin
                cmd.nb_step = 1'b1;
                if (stat.nb_done) state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done) state_next = S_ZAP;
            end
            S_ZAP:
            begin
                cmd.zap_step = 1'b1;
                if (stat.zap_done) state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.best_zero) cmd.emit_miss = 1'b1;
                else cmd.emit_hit = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// ===== design/spcf_dp.sv =====
// Datapath: spectrum memory, serial root, scan, centroid and serial divider.
module spcf_dp
    import spcf_pkg::*;
#(
    parameter int MAG_BINS = MAG_BINS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  spcf_cmd_t                  cmd,
    input  logic [$clog2(MAG_BINS)-1:0] load_addr,
    input  logic                       load_ok,
    input  logic signed [PART_W-1:0]   real_part,
    input  logic signed [PART_W-1:0]   imag_part,
    output spcf_stat_t                 stat,
    output logic                       found,
    output logic [POS_W-1:0]           peak_position_q8,
    output logic [LEVEL_W-1:0]         peak_level,
    output logic                       strobe
);
    localparam int AW = $clog2(MAG_BINS);
    localparam int CW = AW + 1;
    localparam int WSUM_W = MAG_W + AW + 2;
    localparam int DVD_W = WSUM_W + 8;
    localparam int DC_W = $clog2(DVD_W + 1);

    logic [MAG_W-1:0] mem [MAG_BINS];
    logic [MAG_W-1:0] rd_reg;

    // Clearing pass
    logic [CW-1:0] clr_reg;
    // Root
    logic [63:0] rem_reg, root_reg;
    logic [31:0] sq_op;
    logic [63:0] sq_prod;
    logic [4:0]  sq_cnt_reg;
    logic [1:0]  sq_phase_reg;
    logic [31:0] ar_reg, ai_reg;
    logic [AW-1:0] wr_addr_reg;
    logic          wr_ok_reg;
    logic [63:0] trial;
    // Scan
    logic [CW-1:0] scan_reg;
    logic [MAG_W-1:0] best_val_reg;
    logic [AW-1:0] best_idx_reg;
    logic          cmp_live_reg;
    logic [AW-1:0] cmp_idx_reg;
    // Neighbors
    logic [1:0] nb_reg;
    logic [MAG_W-1:0] nbv_reg [3];
    logic [1:0] mul_reg;
    logic [WSUM_W-1:0] wsum_reg;
    logic [LEVEL_W-1:0] sum_reg;
    logic [AW-1:0] mul_k;
    logic [WSUM_W-1:0] prod;
    // Divider
    logic [DVD_W-1:0] dvd_reg, quo_reg;
    logic [LEVEL_W:0] drem_reg;
    logic [LEVEL_W:0] dshift;
    logic [DC_W-1:0]  dcnt_reg;
    logic [1:0] zap_reg;

    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [MAG_W-1:0] wr_data;

    always_comb
    begin
        mem_we = 1'b0;
        wr_addr = wr_addr_reg;
        wr_data = root_reg[MAG_W-1:0];
        if (cmd.clr_step)
        begin
            mem_we = 1'b1;
            wr_addr = clr_reg[AW-1:0];
            wr_data = '0;
        end
        else if (cmd.sq_write)
            mem_we = wr_ok_reg;
        else if (cmd.zap_step)
        begin
            mem_we = 1'b1;
            wr_addr = best_idx_reg - AW'(1) + AW'(zap_reg);
            wr_data = '0;
        end
        // the first neighbor read is issued while the scan finishes
        if (cmd.nb_start)
            rd_addr = best_idx_reg - AW'(1);
        else if (cmd.nb_step)
            rd_addr = best_idx_reg - AW'(1) + AW'(nb_reg);
        else
            rd_addr = scan_reg[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clr_step && !stat.clr_done)
            clr_reg <= clr_reg + CW'(1);
    end
    assign stat.clr_done = (clr_reg == CW'(MAG_BINS - 1));

    // Root: square each part in turn through one multiplier, then 32 digit steps
    assign sq_op = (sq_phase_reg == 2'd0) ? ar_reg : ai_reg;
    assign sq_prod = {32'd0, sq_op} * {32'd0, sq_op};
    assign trial = root_reg + (64'd1 << {sq_cnt_reg, 1'b0});
    always_ff @(posedge clk)
    begin
        if (cmd.sq_start)
        begin
            ar_reg <= real_part[31] ? 32'(-real_part) : real_part;
            ai_reg <= imag_part[31] ? 32'(-imag_part) : imag_part;
            wr_addr_reg <= load_addr;
            wr_ok_reg <= load_ok;
            sq_phase_reg <= 2'd0;
            sq_cnt_reg <= 5'd31;
            root_reg <= '0;
            rem_reg <= '0;
        end
        else if (cmd.sq_step)
        begin
            if (sq_phase_reg == 2'd0)
            begin
                rem_reg <= sq_prod;
                sq_phase_reg <= 2'd1;
            end
            else if (sq_phase_reg == 2'd1)
            begin
                rem_reg <= rem_reg + sq_prod;
                sq_phase_reg <= 2'd2;
            end
            else
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + (64'd1 << {sq_cnt_reg, 1'b0});
                end
                else
                    root_reg <= root_reg >> 1;
                sq_cnt_reg <= sq_cnt_reg - 5'd1;
            end
        end
    end
    assign stat.sq_done = cmd.sq_step && sq_phase_reg == 2'd2 && sq_cnt_reg == 5'd0;

    // Scan: one read per cycle, compare the data of the previous address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
            cmp_live_reg <= 1'b0;
            best_val_reg <= '0;
            best_idx_reg <= '0;
        end
        else if (cmd.scan_start)
        begin
            scan_reg <= CW'(1);
            cmp_live_reg <= 1'b0;
            best_val_reg <= '0;
            best_idx_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            if (scan_reg < CW'(MAG_BINS - 1))
                scan_reg <= scan_reg + CW'(1);
            cmp_live_reg <= (scan_reg < CW'(MAG_BINS - 1));
            cmp_idx_reg <= scan_reg[AW-1:0];
            if (cmp_live_reg && rd_reg > best_val_reg)
            begin
                best_val_reg <= rd_reg;
                best_idx_reg <= cmp_idx_reg;
            end
        end
    end
    assign stat.scan_done = cmd.scan_step && !cmp_live_reg && scan_reg == CW'(MAG_BINS - 1);
    assign stat.best_zero = (best_val_reg == '0);

    // Neighbor reads: address issued, data registered and used in the next cycle
    always_ff @(posedge clk)
    begin
        if (cmd.nb_start)
            nb_reg <= 2'd1;
        else if (cmd.nb_step)
        begin
            nbv_reg[nb_reg - 2'd1] <= rd_reg;
            nb_reg <= nb_reg + 2'd1;
        end
    end
    assign stat.nb_done = cmd.nb_step && nb_reg == 2'd3;

    // Weighted sum: one product per cycle
    assign mul_k = best_idx_reg - AW'(1) + AW'(mul_reg);
    assign prod = WSUM_W'(mul_k) * WSUM_W'(nbv_reg[mul_reg]);
    always_ff @(posedge clk)
    begin
        if (cmd.nb_start)
        begin
            mul_reg <= '0;
            wsum_reg <= '0;
            sum_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            wsum_reg <= wsum_reg + prod;
            sum_reg <= sum_reg + LEVEL_W'(nbv_reg[mul_reg]);
            mul_reg <= mul_reg + 2'd1;
        end
    end
    assign stat.mul_done = cmd.mul_step && mul_reg == 2'd2;

    // Restoring divider, one quotient bit per cycle
    assign dshift = {drem_reg[LEVEL_W-1:0], dvd_reg[DVD_W-1]};
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            // the last product has just landed; include it here
            dvd_reg <= {wsum_reg + prod, 8'd0};
            drem_reg <= '0;
            dcnt_reg <= DC_W'(DVD_W);
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= dvd_reg << 1;
            if (dshift >= {1'b0, sum_reg})
            begin
                drem_reg <= dshift - {1'b0, sum_reg};
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= dshift;
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - DC_W'(1);
            zap_reg <= '0;
        end
        else if (cmd.zap_step)
            zap_reg <= zap_reg + 2'd1;
    end
    assign stat.div_done = cmd.div_step && dcnt_reg == DC_W'(1);
    assign stat.zap_done = cmd.zap_step && zap_reg == 2'd2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe <= 1'b0;
            found <= 1'b0;
            peak_position_q8 <= '0;
            peak_level <= '0;
        end
        else
        begin
            strobe <= cmd.emit_hit | cmd.emit_miss;
            if (cmd.emit_hit)
            begin
                found <= 1'b1;
                peak_position_q8 <= quo_reg[POS_W-1:0];
                peak_level <= sum_reg;
            end
            else if (cmd.emit_miss)
            begin
                found <= 1'b0;
                peak_position_q8 <= '0;
                peak_level <= '0;
            end
        end
    end
endmodule

// ===== design/spectral_peak_centroid_finder.sv =====
// Top level of the spectral peak centroid finder.
// A load (mode 0) stores floor(sqrt(re^2+im^2)) for one bin and keeps busy high
// while the parts are squared in turn through one multiplier, the digit-serial
// square root runs and the memory is written. A peak request (mode 1) scans bins
// 1 to MAG_BINS-2 through the single memory read port, reads the three neighbors,
// accumulates the weighted sum one product a cycle, divides one quotient bit a
// cycle, clears the three bins and presents the result, with busy high throughout;
// when no peak exists it goes from the scan straight to presenting the result.
// Strobe then pulses for one cycle with found, peak_position_q8 and peak_level.
// The receiver cannot stall: sample the result in the strobe cycle. After reset the
// whole spectrum is cleared with busy high. Loads to a bin at or beyond MAG_BINS
// are dropped.
module spectral_peak_centroid_finder
    import spcf_pkg::*;
#(
    parameter int MAG_BINS = MAG_BINS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     mode,
    input  logic [8:0]               bin_index,
    input  logic signed [PART_W-1:0] real_part,
    input  logic signed [PART_W-1:0] imag_part,
    output logic                     strobe,
    output logic                     found,
    output logic [POS_W-1:0]         peak_position_q8,
    output logic [LEVEL_W-1:0]       peak_level
);
    localparam int AW = $clog2(MAG_BINS);

    spcf_cmd_t  cmd;
    spcf_stat_t stat;
    logic [AW-1:0] load_addr;
    logic          load_ok;

    // bins beyond the memory are dropped
    assign load_ok = ({23'd0, bin_index} < 32'(MAG_BINS));
    assign load_addr = AW'(bin_index);

    spcf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    spcf_dp #(.MAG_BINS(MAG_BINS)) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .load_addr        (load_addr),
        .load_ok          (load_ok),
        .real_part        (real_part),
        .imag_part        (imag_part),
        .stat             (stat),
        .found            (found),
        .peak_position_q8 (peak_position_q8),
        .peak_level       (peak_level),
        .strobe           (strobe)
    );
endmodule

// ===== design/spcf_checker.sv =====
// Port-level checker for the peak centroid finder, bound to the top level.
module spcf_checker
    import spcf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               strobe,
    input logic               found,
    input logic [POS_W-1:0]   peak_position_q8,
    input logic [LEVEL_W-1:0] peak_level
);
    // a transfer always makes the block busy next cycle
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("not busy after transfer");
    // results come only while busy
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy)) else $error("result without work");
    // a miss carries zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !found) |-> (peak_level == '0 && peak_position_q8 == '0))
        else $error("miss with data");
    // a hit carries a nonzero level
    a_hit_level: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && found) |-> (peak_level != '0)) else $error("hit with zero level");
endmodule

bind spectral_peak_centroid_finder spcf_checker u_spcf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .strobe           (strobe),
    .found            (found),
    .peak_position_q8 (peak_position_q8),
    .peak_level       (peak_level)
);
